>>> rtl/irte_pkg.sv
// ----------------------------------------------------------------------------
// irte_pkg
// Shared types and constants of the route table engine.
// ----------------------------------------------------------------------------
package irte_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam logic [4:0] MAX_FIXED_RST = 5'd8;
	localparam logic [9:0] DIST_UNREACH = 10'd512;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_GWDOWN = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNREACH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_BADIDX  = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [31:0]        now;
		logic [31:0]        dest_addr;
		logic [31:0]        net_mask;
		logic [31:0]        gateway_addr;
		logic [3:0]         out_port;
		logic [31:0]        lifetime;
		logic [9:0]         distance;
		logic               is_fixed;
		logic signed [31:0] preference;
		logic [5:0]         entry_index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        next_hop;
		logic [3:0]         hop_port;
		logic [31:0]        slot_dest;
		logic [31:0]        slot_mask;
		logic [9:0]         slot_distance;
		logic               slot_in_use;
		logic               slot_fixed;
		logic signed [31:0] slot_preference;
	} res_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [3:0]  port;
		logic [9:0]  distance;
		logic [31:0] expiry;
		logic [31:0] stamp;
		logic [31:0] pref;
	} entry_t;

endpackage

>>> rtl/irte_ram.sv
// ----------------------------------------------------------------------------
// irte_ram
// Route entry memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module irte_ram #(
	parameter int ENTRIES = irte_pkg::ENTRIES_DEF,
	parameter int AW = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  irte_pkg::entry_t  wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output irte_pkg::entry_t  rd_data
);
	import irte_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/irte_ctrl.sv
// ----------------------------------------------------------------------------
// irte_ctrl
// Scan sequencer: walks the table one entry per cycle, selects the best
// route or the slot to replace, writes entries back, and serves entry reads.
// ----------------------------------------------------------------------------
module irte_ctrl #(
	parameter int ENTRIES = irte_pkg::ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  irte_pkg::req_t   req,
	input  logic             req_vld,
	output logic             req_rdy,
	input  logic [4:0]       max_fixed,
	output irte_pkg::res_t   res,
	output logic             res_vld,
	input  logic             res_take
);
	import irte_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FIN   = 3'd2;
	localparam logic [2:0] S_RADDR = 3'd3;
	localparam logic [2:0] S_RDATA = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]         state_q;
	req_t               req_q;
	res_t               res_q;
	logic [CW-1:0]      cnt_q;
	logic               proc_vld_s1;
	logic [AW-1:0]      proc_idx_s1;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] pinned_q;
	logic [5:0]         fixed_cnt_q;
	logic               have_best_q;
	logic [31:0]        best_mask_q;
	logic [9:0]         best_dist_q;
	logic [31:0]        best_gw_q;
	logic [31:0]        best_stamp_q;
	logic [3:0]         best_port_q;
	logic               found_q;
	logic               have_pick_q;
	logic [AW-1:0]      pick_q;
	logic [31:0]        pick_stamp_q;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	entry_t             e;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;
	logic [AW-1:0]      ridx;
	logic [AW-1:0]      sidx;
	logic               exp_hit;
	logic               match;
	logic               exact;
	logic               better;
	logic [31:0]        new_expiry;
	logic               add_ok;
	logic               bad_idx;

	irte_ram #(.ENTRIES(ENTRIES), .AW(AW)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (e)
	);

	assign ridx = req_q.entry_index[AW-1:0];
	assign sidx = (state_q == S_RDATA) ? ridx : proc_idx_s1;
	assign bad_idx = 7'(req.entry_index) >= 7'(ENTRIES);

	assign exp_hit = (e.expiry != 32'd0) && (e.expiry < req_q.now);
	assign match = ((req_q.dest_addr ^ e.dest) & e.mask) == 32'd0;
	assign exact = (e.dest == req_q.dest_addr) && (e.mask == req_q.net_mask)
		&& (e.gateway == req_q.gateway_addr);
	assign new_expiry = (req_q.lifetime != 32'd0) ? req_q.now + req_q.lifetime : 32'd0;

	always_comb begin
		if (e.mask != best_mask_q) begin
			better = (e.distance < best_dist_q) ||
				((e.distance == best_dist_q) && (e.mask > best_mask_q));
		end else if (e.gateway == best_gw_q) begin
			better = e.stamp > best_stamp_q;
		end else begin
			better = e.distance < best_dist_q;
		end
	end

	assign add_ok = !(req_q.is_fixed && (fixed_cnt_q >= {1'b0, max_fixed}))
		&& (found_q || have_pick_q);

	assign rd_en = ((state_q == S_SCAN) && (cnt_q < CW'(ENTRIES))) || (state_q == S_RADDR);
	assign rd_addr = (state_q == S_RADDR) ? ridx : cnt_q[AW-1:0];

	always_comb begin
		wr_en = 1'b0;
		wr_addr = proc_idx_s1;
		wr_data = e;
		if (state_q == S_SCAN && proc_vld_s1 && req_q.operation == OP_GWDOWN
			&& valid_q[proc_idx_s1] && e.gateway == req_q.gateway_addr
			&& !exp_hit && !pinned_q[proc_idx_s1]) begin
			wr_en = 1'b1;
			wr_data.stamp = req_q.now;
			wr_data.expiry = new_expiry;
			wr_data.distance = DIST_UNREACH;
		end else if (state_q == S_FIN && req_q.operation == OP_ADD && add_ok) begin
			wr_en = 1'b1;
			wr_addr = pick_q;
			wr_data.dest = req_q.dest_addr;
			wr_data.mask = req_q.net_mask;
			wr_data.gateway = req_q.gateway_addr;
			wr_data.port = req_q.out_port;
			wr_data.distance = req_q.distance;
			wr_data.expiry = new_expiry;
			wr_data.stamp = req_q.now;
			wr_data.pref = req_q.preference;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			res_q <= '0;
			cnt_q <= '0;
			proc_vld_s1 <= 1'b0;
			proc_idx_s1 <= '0;
			valid_q <= '0;
			pinned_q <= '0;
			fixed_cnt_q <= '0;
			have_best_q <= 1'b0;
			best_mask_q <= '0;
			best_dist_q <= '0;
			best_gw_q <= '0;
			best_stamp_q <= '0;
			best_port_q <= '0;
			found_q <= 1'b0;
			have_pick_q <= 1'b0;
			pick_q <= '0;
			pick_stamp_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_vld) begin
						req_q <= req;
						cnt_q <= '0;
						proc_vld_s1 <= 1'b0;
						have_best_q <= 1'b0;
						found_q <= 1'b0;
						have_pick_q <= 1'b0;
						if (req.operation == OP_READ) begin
							if (bad_idx) begin
								res_q <= '{status: ST_BADIDX, default: '0};
								state_q <= S_DONE;
							end else begin
								res_q <= '0;
								state_q <= S_RADDR;
							end
						end else begin
							res_q <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					proc_vld_s1 <= cnt_q < CW'(ENTRIES);
					proc_idx_s1 <= cnt_q[AW-1:0];
					if (cnt_q < CW'(ENTRIES)) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_FIN;
					end
					if (proc_vld_s1) begin
						case (req_q.operation)
							OP_LOOKUP: begin
								if (valid_q[sidx]) begin
									if (exp_hit) begin
										valid_q[sidx] <= 1'b0;
									end else if (match && (!have_best_q || better)) begin
										have_best_q <= 1'b1;
										best_mask_q <= e.mask;
										best_dist_q <= e.distance;
										best_gw_q <= e.gateway;
										best_stamp_q <= e.stamp;
										best_port_q <= e.port;
									end
								end
							end
							OP_ADD: begin
								if (!found_q) begin
									if (!valid_q[sidx] || exp_hit) begin
										pick_q <= sidx;
										found_q <= 1'b1;
									end else if (exact) begin
										if (req_q.is_fixed || !pinned_q[sidx]) begin
											pick_q <= sidx;
											found_q <= 1'b1;
										end
									end else if (!pinned_q[sidx] &&
										(!have_pick_q || e.stamp < pick_stamp_q)) begin
										pick_q <= sidx;
										pick_stamp_q <= e.stamp;
										have_pick_q <= 1'b1;
									end
								end
							end
							OP_GWDOWN: begin
								if (valid_q[sidx] && e.gateway == req_q.gateway_addr
									&& exp_hit) begin
									valid_q[sidx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FIN: begin
					state_q <= S_DONE;
					if (req_q.operation == OP_LOOKUP) begin
						if (!have_best_q || best_dist_q > req_q.distance) begin
							res_q.status <= ST_UNREACH;
						end else begin
							res_q.next_hop <= best_gw_q;
							res_q.hop_port <= best_port_q;
						end
					end else if (req_q.operation == OP_ADD) begin
						if (add_ok) begin
							valid_q[pick_q] <= 1'b1;
							pinned_q[pick_q] <= req_q.is_fixed;
							fixed_cnt_q <= fixed_cnt_q + {5'd0, req_q.is_fixed};
						end else begin
							res_q.status <= ST_FULL;
						end
					end
				end
				S_RADDR: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					state_q <= S_DONE;
					if (exp_hit) begin
						valid_q[sidx] <= 1'b0;
					end
					res_q.next_hop <= e.gateway;
					res_q.hop_port <= e.port;
					res_q.slot_dest <= e.dest;
					res_q.slot_mask <= e.mask;
					res_q.slot_distance <= e.distance;
					res_q.slot_in_use <= valid_q[sidx] && !exp_hit;
					res_q.slot_fixed <= valid_q[sidx] && !exp_hit && pinned_q[sidx];
					res_q.slot_preference <= e.pref;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_rdy = state_q == S_IDLE;
	assign res_vld = state_q == S_DONE;
	assign res = res_q;

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN || state_q == S_FIN))
		else $error("table write outside a scan");
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (AW+1)'(rd_addr) < (AW+1)'(ENTRIES))
		else $error("read address out of range");
	a_fixed_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fixed_cnt_q >= $past(fixed_cnt_q))
		else $error("fixed route count fell");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_DONE)
		else $error("finish did not present a result");

endmodule

>>> rtl/ip_route_table_engine_top.sv
// ----------------------------------------------------------------------------
// ip_route_table_engine_top
// Route table with masked lookup, add, gateway-down and entry read.
//
//   channel  handshake                 payload
//   in       in_valid / in_stall       operation .. entry_index
//   out      out_valid / out_stall     status .. slot_preference
//   cfg      cfg_wr_en                 cfg_wr_data (max fixed routes)
//
// lookup, add and gateway-down visit every entry before a result shows:
// the table memory is scanned one entry per cycle through its single read port.
// read entry reads the addressed slot, a bad index skips the read; the next
// transaction is taken only after the result moves to the output register.
// reset clears all valid and fixed marks and the fixed count at once.
// a new transaction is taken while a finished result waits on out_stall.
// ----------------------------------------------------------------------------
module ip_route_table_engine_top #(
	parameter int ENTRIES = irte_pkg::ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [4:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [31:0]        now,
	input  logic [31:0]        dest_addr,
	input  logic [31:0]        net_mask,
	input  logic [31:0]        gateway_addr,
	input  logic [3:0]         out_port,
	input  logic [31:0]        lifetime,
	input  logic [9:0]         distance,
	input  logic               is_fixed,
	input  logic signed [31:0] preference,
	input  logic [5:0]         entry_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [31:0]        next_hop,
	output logic [3:0]         hop_port,
	output logic [31:0]        slot_dest,
	output logic [31:0]        slot_mask,
	output logic [9:0]         slot_distance,
	output logic               slot_in_use,
	output logic               slot_fixed,
	output logic signed [31:0] slot_preference
);
	import irte_pkg::*;

	logic [4:0] max_fixed_q;
	req_t       req;
	logic       req_rdy;
	res_t       res;
	logic       res_vld;
	logic       res_take;
	logic       out_valid_q;
	res_t       out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fixed_q <= MAX_FIXED_RST;
		end else if (cfg_wr_en) begin
			max_fixed_q <= cfg_wr_data;
		end
	end

	always_comb begin
		req.operation = operation;
		req.now = now;
		req.dest_addr = dest_addr;
		req.net_mask = net_mask;
		req.gateway_addr = gateway_addr;
		req.out_port = out_port;
		req.lifetime = lifetime;
		req.distance = distance;
		req.is_fixed = is_fixed;
		req.preference = preference;
		req.entry_index = entry_index;
	end

	irte_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_vld   (in_valid),
		.req_rdy   (req_rdy),
		.max_fixed (max_fixed_q),
		.res       (res),
		.res_vld   (res_vld),
		.res_take  (res_take)
	);

	assign in_stall = !req_rdy;
	assign res_take = res_vld && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			out_q <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign next_hop = out_q.next_hop;
	assign hop_port = out_q.hop_port;
	assign slot_dest = out_q.slot_dest;
	assign slot_mask = out_q.slot_mask;
	assign slot_distance = out_q.slot_distance;
	assign slot_in_use = out_q.slot_in_use;
	assign slot_fixed = out_q.slot_fixed;
	assign slot_preference = out_q.slot_preference;

endmodule
